[design/hnm_pkg.sv]
// shared constants, register codes and controller/datapath interface types
package hnm_pkg;

  localparam int MAX_SIDE_DEF = 1024;

  localparam int H_W      = 32;
  localparam int COL_W    = 10;
  localparam int HALF_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int SIDE_W   = 11;
  localparam int STEP_W   = 31;
  localparam int DIFF_W   = 33;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 64;
  localparam int LEN_W    = 66;
  localparam int ACC_W    = 82;
  localparam int MA_W     = 33;
  localparam int MB_W     = 17;
  localparam int PP_W     = 50;
  localparam int JOBS     = 4;
  localparam int COMPS    = 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_A_W    = 3;
  localparam int CFG_D_W    = 32;

  localparam logic REG_SIDE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RST = 11'd1024;
  localparam logic [STEP_W-1:0] STEP_RST = 31'd65536;
  localparam logic [BYTE_W-1:0] ZERO_LEN_CODE = 8'd127;

  typedef struct packed {
    logic       accept;
    logic       build;
    logic       load;
    logic [1:0] jsel;
    logic [1:0] ksel;
    logic       mul_en;
    logic       mul_chunk;
    logic       mul_len;
    logic       acc_clr;
    logic       acc_add;
    logic       sq_store;
    logic       len_calc;
    logic       prep;
    logic       dec;
    logic       dec_last;
    logic       norm;
    logic       finish;
  } hnm_cmd_t;

  typedef struct packed {
    logic [JOBS-1:0] job_v;
    logic            norm_done;
  } hnm_sts_t;

endpackage

[design/hnm_ctrl.sv]
// sequencer: item intake, result selection, square/search/normalize steps, output handshake
module hnm_ctrl import hnm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  hnm_sts_t sts,
  output hnm_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_PICK = 4'd2;
  localparam logic [3:0] S_LOAD = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_SQST = 4'd5;
  localparam logic [3:0] S_LEN  = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_MUL  = 4'd8;
  localparam logic [3:0] S_DEC  = 4'd9;
  localparam logic [3:0] S_NORM = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam logic [2:0] J_END  = 3'd4;
  localparam logic [1:0] K_LAST = 2'd2;
  localparam logic [2:0] I_LAST = 3'd7;
  localparam logic [1:0] PH_END = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [2:0] j_r, j_nxt;
  logic [1:0] k_r, k_nxt;
  logic [2:0] it_r, it_nxt;
  logic [1:0] ph_r, ph_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    it_nxt    = it_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    cmd.jsel  = j_r[1:0];
    cmd.ksel  = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        cmd.build = 1'b1;
        j_nxt     = 3'd0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (j_r == J_END) begin
          state_nxt = S_IDLE;
        end else if (sts.job_v[j_r[1:0]]) begin
          state_nxt = S_LOAD;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        k_nxt     = 2'd0;
        ph_nxt    = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ, S_MUL: begin
        cmd.mul_len   = (state_r == S_MUL);
        cmd.mul_en    = (ph_r != PH_END);
        cmd.mul_chunk = (ph_r == 2'd1);
        cmd.acc_clr   = (ph_r == 2'd0);
        cmd.acc_add   = (ph_r != 2'd0);
        if (ph_r == PH_END) begin
          ph_nxt    = 2'd0;
          state_nxt = (state_r == S_MUL) ? S_DEC : S_SQST;
        end else begin
          ph_nxt = ph_r + 2'd1;
        end
      end
      S_SQST: begin
        cmd.sq_store = 1'b1;
        if (k_r == K_LAST) begin
          k_nxt     = 2'd0;
          state_nxt = S_LEN;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_LEN: begin
        cmd.len_calc = 1'b1;
        state_nxt    = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        it_nxt    = 3'd0;
        ph_nxt    = 2'd0;
        state_nxt = S_MUL;
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (it_r == I_LAST) begin
          cmd.dec_last = 1'b1;
          if (k_r == K_LAST) begin
            state_nxt = S_NORM;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_PREP;
          end
        end else begin
          it_nxt    = it_r + 3'd1;
          state_nxt = S_MUL;
        end
      end
      S_NORM: begin
        cmd.norm = 1'b1;
        if (sts.norm_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          j_nxt     = j_r + 3'd1;
          state_nxt = S_PICK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      k_r     <= '0;
      it_r    <= '0;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      it_r    <= it_nxt;
      ph_r    <= ph_nxt;
    end
  end

endmodule

[design/hnm_dp.sv]
// datapath: line buffer, neighbor bookkeeping, shared multiplier, byte search, half conversion
module hnm_dp import hnm_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  hnm_cmd_t                 cmd,
  output hnm_sts_t                 sts,
  input  logic [SIDE_W-1:0]        side_count,
  input  logic [STEP_W-1:0]        grid_step,
  input  logic                     restart,
  input  logic signed [H_W-1:0]    in_height,
  output logic [COL_W-1:0]         out_column,
  output logic [COL_W-1:0]         out_row,
  output logic [HALF_W-1:0]        out_half_height,
  output logic [BYTE_W-1:0]        out_normal_red,
  output logic [BYTE_W-1:0]        out_normal_green,
  output logic [BYTE_W-1:0]        out_normal_blue,
  output logic signed [H_W-1:0]    out_min_height,
  output logic signed [H_W-1:0]    out_max_height,
  output logic                     out_grid_done
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int NW = $clog2(MAX_SIDE + 1);
  localparam int SW = (NW > SIDE_W) ? NW : SIDE_W;

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [H_W-1:0] a,
                                                      input logic signed [H_W-1:0] b);
    sdiff = {a[H_W-1], a} - {b[H_W-1], b};
  endfunction

  function automatic logic [MAG_W-1:0] dmag(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    dmag = v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // effective side
  logic [SW-1:0] side_e;
  logic [NW-1:0] n, nm1;
  always_comb begin
    side_e = SW'(side_count);
    if (side_e < SW'(2)) begin
      n = NW'(2);
    end else if (side_e > SW'(MAX_SIDE)) begin
      n = NW'(MAX_SIDE);
    end else begin
      n = NW'(side_e);
    end
    nm1 = n - NW'(1);
  end

  logic [H_W-1:0] row_mem [MAX_SIDE];

  logic [CW-1:0] col_r, row_r, x_r, z_r;
  logic signed [H_W-1:0] h_r, rd0_r, rd1_r, prev_r, sln_r, sblc_r, sbfc_r, min_r, max_r;

  logic          wrap_now;
  logic [CW-1:0] x_now, z_now, addr1;
  assign wrap_now = (NW'(col_r) >= n) || (NW'(row_r) >= n);
  assign x_now    = wrap_now ? '0 : col_r;
  assign z_now    = wrap_now ? '0 : row_r;
  assign addr1    = (x_now == CW'(MAX_SIDE - 1)) ? '0 : x_now + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd0_r <= row_mem[x_now];
      rd1_r <= row_mem[addr1];
    end
    if (cmd.build) begin
      row_mem[x_r] <= h_r;
    end
  end

  logic x_last, z_last, x_ge1, z_ge1;
  assign x_last = (NW'(x_r) == nm1);
  assign z_last = (NW'(z_r) == nm1);
  assign x_ge1  = (x_r != '0);
  assign z_ge1  = (z_r != '0);

  // result candidates of one transaction
  logic [JOBS-1:0]             job_v_r;
  logic [CW-1:0]               job_col_r [JOBS];
  logic [CW-1:0]               job_row_r [JOBS];
  logic signed [H_W-1:0]       job_hv_r  [JOBS];
  logic signed [DIFF_W-1:0]    job_ax_r  [JOBS];
  logic signed [DIFF_W-1:0]    job_az_r  [JOBS];
  logic [JOBS-1:0]             job_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      prev_r  <= '0;
      sln_r   <= '0;
      sblc_r  <= '0;
      sbfc_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
      job_v_r <= '0;
    end else if (restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      if (cmd.accept) begin
        x_r <= x_now;
        z_r <= z_now;
        h_r <= in_height;
        col_r <= x_now;
        row_r <= z_now;
        if ((x_now == '0) && (z_now == '0)) begin
          min_r <= in_height;
          max_r <= in_height;
        end else begin
          if (in_height < min_r) min_r <= in_height;
          if (in_height > max_r) max_r <= in_height;
        end
      end
      if (cmd.build) begin
        job_v_r[0]    <= z_ge1 && !x_last;
        job_col_r[0]  <= x_r;
        job_row_r[0]  <= z_r - CW'(1);
        job_hv_r[0]   <= rd0_r;
        job_ax_r[0]   <= sdiff(rd0_r, rd1_r);
        job_az_r[0]   <= sdiff(rd0_r, h_r);
        job_done_r[0] <= 1'b0;

        job_v_r[1]    <= (z_r == CW'(1)) && x_last;
        job_col_r[1]  <= x_r;
        job_row_r[1]  <= '0;
        job_hv_r[1]   <= rd0_r;
        job_ax_r[1]   <= sdiff(sln_r, rd0_r);
        job_az_r[1]   <= sdiff(rd0_r, h_r);
        job_done_r[1] <= 1'b0;

        job_v_r[2]    <= z_last && (x_r == CW'(1));
        job_col_r[2]  <= '0;
        job_row_r[2]  <= z_r;
        job_hv_r[2]   <= prev_r;
        job_ax_r[2]   <= sdiff(prev_r, h_r);
        job_az_r[2]   <= sdiff(sbfc_r, prev_r);
        job_done_r[2] <= 1'b0;

        job_v_r[3]    <= z_ge1 && x_ge1 && (x_last || z_last);
        job_col_r[3]  <= x_r;
        job_row_r[3]  <= z_r;
        job_hv_r[3]   <= h_r;
        job_ax_r[3]   <= sdiff(prev_r, h_r);
        job_az_r[3]   <= x_last ? sdiff(sblc_r, h_r) : sdiff(rd0_r, h_r);
        job_done_r[3] <= x_last && z_last;

        if (z_last && !x_ge1) sbfc_r <= rd0_r;
        if (x_last) begin
          sln_r  <= prev_r;
          sblc_r <= h_r;
        end
        prev_r <= h_r;
        if (x_last) begin
          col_r <= '0;
          row_r <= z_last ? '0 : z_r + CW'(1);
        end else begin
          col_r <= x_r + CW'(1);
          row_r <= z_r;
        end
      end
    end
  end

  // working copy of the selected result
  logic [CW-1:0]        w_col_r, w_row_r;
  logic                 w_done_r;
  logic [MAG_W-1:0]     w_mag_r [COMPS];
  logic [COMPS-1:0]     w_neg_r;
  logic [MAG_W-1:0]     a_r, v_r;
  logic                 sign_r;
  logic [4:0]           p_r;
  logic [HALF_W-1:0]    half_r;

  logic [MAG_W-1:0]     hv_mag;
  logic signed [H_W-1:0] hv_sel, hv_neg;
  assign hv_sel = job_hv_r[cmd.jsel];
  assign hv_neg = -hv_sel;
  assign hv_mag = hv_sel[H_W-1] ? hv_neg : hv_sel;

  // shared 33x17 multiplier with registered partial product
  logic [MA_W-1:0]   op_a;
  logic [MB_W-1:0]   op_b;
  logic [5:0]        sh;
  logic [PP_W-1:0]   pp_r;
  logic [5:0]        sh_r;
  logic [ACC_W-1:0]  acc_r;
  logic [SQ_W-1:0]   sq_r [COMPS];
  logic [LEN_W-1:0]  len2_r;
  logic [ACC_W-1:0]  c2x_r;
  logic [MAG_W-1:0]  mag_sel;
  logic [15:0]       m2_r;

  assign mag_sel = w_mag_r[cmd.ksel];

  always_comb begin
    if (cmd.mul_len) begin
      op_a = cmd.mul_chunk ? len2_r[LEN_W-1:MA_W] : len2_r[MA_W-1:0];
      op_b = {1'b0, m2_r};
      sh   = cmd.mul_chunk ? 6'd33 : 6'd0;
    end else begin
      op_a = {1'b0, mag_sel};
      op_b = {1'b0, cmd.mul_chunk ? mag_sel[31:16] : mag_sel[15:0]};
      sh   = cmd.mul_chunk ? 6'd16 : 6'd0;
    end
  end

  // byte search state
  logic [BYTE_W-1:0] lo_r, hi_r, mid_r, lo_nxt, hi_nxt, mid_nxt;
  logic              mpos_r, mpos_nxt, ok;
  logic [8:0]        mid_sum, mid2, mab9;
  logic [15:0]       m2_nxt;
  logic [BYTE_W-1:0] byte_r [COMPS];
  logic              cneg, len_zero;

  assign cneg     = w_neg_r[cmd.ksel];
  assign len_zero = (len2_r == '0);

  always_comb begin
    if (mpos_r) begin
      ok = !cneg && (acc_r <= c2x_r);
    end else begin
      ok = !cneg || (c2x_r <= acc_r);
    end
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.prep) begin
      lo_nxt = '0;
      hi_nxt = 8'd255;
    end else if (cmd.dec) begin
      if (ok) begin
        lo_nxt = mid_r;
      end else begin
        hi_nxt = mid_r - 8'd1;
      end
    end
    mid_sum  = {1'b0, lo_nxt} + {1'b0, hi_nxt} + 9'd1;
    mid_nxt  = mid_sum[8:1];
    mid2     = {mid_nxt, 1'b0};
    mpos_nxt = mid_nxt[7];
    mab9     = mpos_nxt ? (mid2 - 9'd255) : (9'd255 - mid2);
    m2_nxt   = mab9[7:0] * mab9[7:0];
  end

  // half assembly
  logic              rnd;
  logic [11:0]       q;
  logic [4:0]        e;
  logic [14:0]       body;
  logic [HALF_W-1:0] half_nxt;
  always_comb begin
    rnd  = v_r[20] && ((|v_r[19:0]) || v_r[21]);
    q    = {1'b0, v_r[31:21]} + {11'd0, rnd};
    e    = p_r - 5'd2;
    body = {e, 10'd0} + {3'd0, q};
    if (a_r == '0) begin
      half_nxt = '0;
    end else if (a_r < MAG_W'(4)) begin
      half_nxt = {sign_r, 5'd0, a_r[1:0], 8'd0};
    end else begin
      half_nxt = {sign_r, body};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_col_r    <= job_col_r[cmd.jsel];
      w_row_r    <= job_row_r[cmd.jsel];
      w_done_r   <= job_done_r[cmd.jsel];
      w_mag_r[0] <= dmag(job_ax_r[cmd.jsel]);
      w_mag_r[1] <= dmag(job_az_r[cmd.jsel]);
      w_mag_r[2] <= {1'b0, grid_step};
      w_neg_r    <= {1'b0, job_az_r[cmd.jsel][DIFF_W-1], job_ax_r[cmd.jsel][DIFF_W-1]};
      a_r        <= hv_mag;
      v_r        <= hv_mag;
      sign_r     <= hv_sel[H_W-1];
      p_r        <= 5'd31;
    end
    if (cmd.mul_en) begin
      pp_r <= PP_W'(op_a * op_b);
      sh_r <= sh;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + (ACC_W'(pp_r) << sh_r);
    end
    if (cmd.sq_store) begin
      sq_r[cmd.ksel] <= acc_r[SQ_W-1:0];
    end
    if (cmd.len_calc) begin
      len2_r <= LEN_W'(sq_r[0]) + LEN_W'(sq_r[1]) + LEN_W'(sq_r[2]);
    end
    if (cmd.prep) begin
      c2x_r <= (ACC_W'(sq_r[cmd.ksel]) << 16) - (ACC_W'(sq_r[cmd.ksel]) << 9)
             + ACC_W'(sq_r[cmd.ksel]);
    end
    if (cmd.prep || cmd.dec) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      mid_r  <= mid_nxt;
      mpos_r <= mpos_nxt;
      m2_r   <= m2_nxt;
    end
    if (cmd.dec_last) begin
      byte_r[cmd.ksel] <= len_zero ? ZERO_LEN_CODE : lo_nxt;
    end
    if (cmd.norm && !sts.norm_done) begin
      if (v_r[31:24] == 8'd0) begin
        v_r <= v_r << 8;
        p_r <= p_r - 5'd8;
      end else begin
        v_r <= v_r << 1;
        p_r <= p_r - 5'd1;
      end
    end
    if (cmd.finish) begin
      half_r <= half_nxt;
    end
  end

  assign sts.job_v     = job_v_r;
  assign sts.norm_done = v_r[31] || (v_r == '0);

  assign out_column       = COL_W'(w_col_r);
  assign out_row          = COL_W'(w_row_r);
  assign out_half_height  = half_r;
  assign out_normal_red   = byte_r[0];
  assign out_normal_green = byte_r[1];
  assign out_normal_blue  = byte_r[2];
  assign out_min_height   = min_r;
  assign out_max_height   = max_r;
  assign out_grid_done    = w_done_r;

endmodule

[design/heightmap_normal_map_encoder.sv]
// top level: configuration registers, stream ports, controller and datapath
// each result of an item takes 3 squares and 24 search products on one shared
// 33x17 multiplier, followed by a normalize loop for the half height
// one item at a time: no new input is taken until every result of the last is sent
// synchronous active-low reset clears control and counters and returns the configuration registers to defaults
module heightmap_normal_map_encoder import hnm_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // height[31:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // column, row, half_height, normal_red,
                                            // normal_green, normal_blue, min_height,
                                            // max_height, zero pad
  output logic                  out_tlast,  // grid_done
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_A_W-1:0]    cfg_paddr,
  input  logic [CFG_D_W-1:0]    cfg_pwdata,
  output logic [CFG_D_W-1:0]    cfg_prdata,
  output logic                  cfg_pready
);

  logic [SIDE_W-1:0] side_r;
  logic [STEP_W-1:0] step_r;
  logic              wr, restart;
  logic              idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[2];
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign restart    = wr && (idx == REG_SIDE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RST;
      step_r <= STEP_RST;
    end else if (wr) begin
      if (idx == REG_SIDE) begin
        side_r <= cfg_pwdata[SIDE_W-1:0];
      end else begin
        step_r <= cfg_pwdata[STEP_W-1:0];
      end
    end
  end

  always_comb begin
    case (idx)
      REG_SIDE: cfg_prdata = CFG_D_W'(side_r);
      REG_STEP: cfg_prdata = CFG_D_W'(step_r);
      default:  cfg_prdata = '0;
    endcase
  end

  hnm_cmd_t cmd;
  hnm_sts_t sts;

  logic [COL_W-1:0]      o_col, o_row;
  logic [HALF_W-1:0]     o_half;
  logic [BYTE_W-1:0]     o_red, o_green, o_blue;
  logic signed [H_W-1:0] o_min, o_max;

  hnm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hnm_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .side_count       (side_r),
    .grid_step        (step_r),
    .restart          (restart),
    .in_height        ($signed(in_tdata[H_W-1:0])),
    .out_column       (o_col),
    .out_row          (o_row),
    .out_half_height  (o_half),
    .out_normal_red   (o_red),
    .out_normal_green (o_green),
    .out_normal_blue  (o_blue),
    .out_min_height   (o_min),
    .out_max_height   (o_max),
    .out_grid_done    (out_tlast)
  );

  assign out_tdata = {4'd0, o_max, o_min, o_blue, o_green, o_red, o_half, o_row, o_col};

endmodule

[design/hnm_check.sv]
// port-level assertion checker, bound to the top level
module hnm_check import hnm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input open while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !out_tvalid)
    else $error("no lookup cycle after input transaction");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_pready)
    else $error("ports not idle after reset");

endmodule

bind heightmap_normal_map_encoder hnm_check u_hnm_check (.*);

[tb/tb_heightmap_normal_map_encoder.sv]
// testbench for heightmap_normal_map_encoder: predicted normals and extremes checked per result
`timescale 1ns / 100ps

module tb_heightmap_normal_map_encoder;
  import hnm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [CFG_A_W-1:0] ADDR_SIDE = CFG_A_W'(4 * REG_SIDE);
  localparam logic [CFG_A_W-1:0] ADDR_STEP = CFG_A_W'(4 * REG_STEP);

  typedef struct {
    logic [COL_W-1:0]  column;
    logic [COL_W-1:0]  row;
    logic [HALF_W-1:0] half_height;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [H_W-1:0]    min_h;
    logic [H_W-1:0]    max_h;
    logic              done;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_A_W-1:0] cfg_paddr = '0;
  logic [CFG_D_W-1:0] cfg_pwdata = '0;
  logic [CFG_D_W-1:0] cfg_prdata;
  logic cfg_pready;

  heightmap_normal_map_encoder dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // grid model
  int unsigned side_reg, step_reg;
  longint line_buf[MAX_SIDE_DEF];
  int unsigned col_cnt, row_cnt;
  longint prev_h, left_nb, back_last, back_first, min_h, max_h;
  pixel_t pixel_q[$];

  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit stall_req = 0;
  int hold_left = 0;
  longint unsigned cycles = 0;

  function automatic bit [63:0] magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [BYTE_W-1:0] encode_comp(longint c, bit [127:0] len2);
    bit [127:0] ca, c2, lm;
    int lo, hi, mid, m;
    bit ok;
    ca = magn(c);
    c2 = ca * ca * 128'd65025;
    lo = 0;
    hi = 255;
    if (len2 == 0) return ZERO_LEN_CODE;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      m = 2 * mid - 255;
      lm = len2 * 128'(m * m);
      if (m > 0) ok = (c >= 0) && (lm <= c2);
      else ok = (c >= 0) || (c2 <= lm);
      if (ok) lo = mid;
      else hi = mid - 1;
    end
    return BYTE_W'(lo);
  endfunction

  function automatic logic [HALF_W-1:0] half_of(longint h);
    bit [15:0] sgn;
    bit [63:0] a, q, rem, hw;
    int p, r;
    bit [31:0] m;
    sgn = h < 0 ? 16'h8000 : 16'h0;
    a = magn(h);
    p = 0;
    if (a == 0) return 16'h0;
    if (a < 4) return sgn | 16'(a << 8);
    while (p < 40 && (a >> (p + 1)) != 0) p++;
    if (p <= 10) begin
      m = 32'(a << (10 - p));
    end else begin
      r = p - 10;
      q = a >> r;
      rem = a & ((64'd1 << r) - 1);
      hw = 64'd1 << (r - 1);
      if (rem > hw || (rem == hw && q[0])) q++;
      m = 32'(q);
    end
    return sgn | 16'((((p - 2) << 10) + m) & 32'h7fff);
  endfunction

  function automatic void push_pixel(int unsigned c, int unsigned r, longint hv,
                                     longint ax, longint az, bit done);
    pixel_t px;
    bit [127:0] len2;
    longint s;
    s = longint'(step_reg);
    len2 = 128'(magn(ax)) * 128'(magn(ax)) + 128'(magn(az)) * 128'(magn(az))
         + 128'(s) * 128'(s);
    px.column = COL_W'(c);
    px.row = COL_W'(r);
    px.half_height = half_of(hv);
    px.red = encode_comp(ax, len2);
    px.green = encode_comp(az, len2);
    px.blue = encode_comp(s, len2);
    px.min_h = H_W'(min_h);
    px.max_h = H_W'(max_h);
    px.done = done;
    pixel_q.push_back(px);
  endfunction

  function automatic void predict_sample(logic [H_W-1:0] raw);
    int unsigned n, x, z;
    longint h, hc, hb;
    n = side_reg;
    if (n < 2) n = 2;
    if (n > MAX_SIDE_DEF) n = MAX_SIDE_DEF;
    if (col_cnt >= n || row_cnt >= n) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    x = col_cnt;
    z = row_cnt;
    h = longint'($signed(raw));
    if (x == 0 && z == 0) begin
      min_h = h;
      max_h = h;
    end else begin
      if (h < min_h) min_h = h;
      if (h > max_h) max_h = h;
    end
    if (z >= 1 && x < n - 1) begin
      hc = line_buf[x];
      push_pixel(x, z - 1, hc, hc - line_buf[x + 1], hc - h, 0);
    end
    if (z == 1 && x == n - 1) begin
      hc = line_buf[n - 1];
      push_pixel(n - 1, 0, hc, left_nb - hc, hc - h, 0);
    end
    if (z == n - 1 && x == 1)
      push_pixel(0, n - 1, prev_h, prev_h - h, back_first - prev_h, 0);
    if (z >= 1 && x >= 1 && (x == n - 1 || z == n - 1)) begin
      hb = (x == n - 1) ? back_last : line_buf[x];
      push_pixel(x, z, h, prev_h - h, hb - h, (x == n - 1 && z == n - 1));
    end
    if (z == n - 1 && x == 0) back_first = line_buf[0];
    if (x == n - 1) begin
      left_nb = prev_h;
      back_last = h;
    end
    line_buf[x] = h;
    prev_h = h;
    x++;
    if (x >= n) begin
      x = 0;
      z++;
      if (z >= n) z = 0;
    end
    col_cnt = x;
    row_cnt = z;
  endfunction

  // result checker
  always @(posedge clk) begin
    pixel_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("heightmap_normal_map_encoder: mismatch");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_tdata[9:0] !== e.column) begin
          $error("column exp %0d got %0d", e.column, out_tdata[9:0]); errors++;
        end
        if (out_tdata[19:10] !== e.row) begin
          $error("row exp %0d got %0d", e.row, out_tdata[19:10]); errors++;
        end
        if (out_tdata[35:20] !== e.half_height) begin
          $error("half_height exp %h got %h", e.half_height, out_tdata[35:20]); errors++;
        end
        if (out_tdata[43:36] !== e.red) begin
          $error("normal_red exp %0d got %0d", e.red, out_tdata[43:36]); errors++;
        end
        if (out_tdata[51:44] !== e.green) begin
          $error("normal_green exp %0d got %0d", e.green, out_tdata[51:44]); errors++;
        end
        if (out_tdata[59:52] !== e.blue) begin
          $error("normal_blue exp %0d got %0d", e.blue, out_tdata[59:52]); errors++;
        end
        if (out_tdata[91:60] !== e.min_h) begin
          $error("min_height exp %h got %h", e.min_h, out_tdata[91:60]); errors++;
        end
        if (out_tdata[123:92] !== e.max_h) begin
          $error("max_height exp %h got %h", e.max_h, out_tdata[123:92]); errors++;
        end
        if (out_tlast !== e.done) begin
          $error("grid_done exp %0d got %0d", e.done, out_tlast); errors++;
        end
      end
    end
  end

  // receiver with random idling and a long hold-off on request
  always @(posedge clk) begin
    if (stall_req) begin
      stall_req = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_height(logic [H_W-1:0] v);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(v);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_SIDE) begin
      side_reg = data & 32'h7ff;
      col_cnt = 0;
      row_cnt = 0;
    end else if (addr == ADDR_STEP) begin
      step_reg = data & 32'h7fffffff;
    end
  endtask

  function automatic logic [H_W-1:0] rand_height();
    case ($urandom_range(5))
      0: return 32'h7fffffff - $urandom_range(3);
      1: return 32'h80000000 + $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_grid(int n);
    repeat (n * n) send_height(rand_height());
  endtask

  task automatic test_directed();
    write_reg(ADDR_SIDE, 2);
    send_height(32'h7fffffff);
    send_height(32'h80000000);
    send_height(32'h0);
    send_height(32'hffffffff);
    wait_idle();
    write_reg(ADDR_SIDE, 3);
    send_height(32'h00000003);
    send_height(32'h00010000);
    send_height(32'h80000000);
    send_height(32'h7fffffff);
    send_height(32'h00000001);
    send_height(32'hfffffffd);
    send_height(32'h00000800);
    send_height(32'h00000fff);
    send_height(32'h12345678);
    wait_idle();
    // zero-length vector
    write_reg(ADDR_STEP, 0);
    write_reg(ADDR_SIDE, 2);
    repeat (4) send_height(32'h00050000);
    wait_idle();
    write_reg(ADDR_STEP, 32'h7fffffff);
    write_reg(ADDR_SIDE, 0);
    send_height(32'h55555555);
    send_height(32'haaaaaaaa);
    send_height(32'h7fffffff);
    send_height(32'h80000000);
    wait_idle();
    // oversized side clamps to max, then restart cuts the grid short
    write_reg(ADDR_SIDE, 11'h7ff);
    repeat (3) send_height(rand_height());
    wait_idle();
    write_reg(ADDR_SIDE, 1025);
    send_height(32'h1);
    wait_idle();
  endtask

  task automatic test_random_phase(int tx_pct, int rx_pct);
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (3) begin
      n = $urandom_range(2, 5);
      write_reg(ADDR_SIDE, n);
      write_reg(ADDR_STEP, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 200000));
      send_grid(n);
      if ($urandom_range(1)) repeat ($urandom_range(1, 4)) send_height(rand_height());
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(ADDR_SIDE, 3);
    write_reg(ADDR_STEP, 65536);
    stall_req = 1;
    send_grid(3);
    send_grid(3);
    wait_idle();
  endtask

  initial begin
    side_reg = SIDE_RST;
    step_reg = STEP_RST;
    col_cnt = 0;
    row_cnt = 0;
    prev_h = 0;
    left_nb = 0;
    back_last = 0;
    back_first = 0;
    min_h = 0;
    max_h = 0;
    foreach (line_buf[i]) line_buf[i] = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 26;
    rx_idle_pct = 60;
    test_directed();
    test_random_phase(26, 60);
    test_random_phase(60, 26);
    test_random_phase(0, 0);
    test_backpressure();
    if (errors == 0) begin
      $display("heightmap_normal_map_encoder: match");
    end else begin
      $display("heightmap_normal_map_encoder: mismatch");
    end
    $finish;
  end

endmodule

[heightmap_normal_map_encoder.f]
design/hnm_pkg.sv
design/hnm_ctrl.sv
design/hnm_dp.sv
design/heightmap_normal_map_encoder.sv
design/hnm_check.sv
tb/tb_heightmap_normal_map_encoder.sv
